FILE: hdl/sss_pkg.sv
// shared types and constants for the sequence store sort/search block
// no dependencies; every other file refers to this package by scoped names
package sss_pkg;

   localparam int CAPACITY   = 16;
   localparam int DATA_W     = 32;
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int ACTION_W   = 3;
   localparam int POS_W      = 4;
   localparam int HELD_W     = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CAPACITY-1:0]      mask_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic [HELD_W-1:0]        held_type;

   // csr register indexes (byte address bits above the word offset)
   localparam logic REG_FILTER_THRESHOLD = 1'b0;
   localparam data_type THRESHOLD_RESET = 32'sd4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_APPEND     = 3'd0,
      ACT_PUSH_FRONT = 3'd1,
      ACT_CLEAR      = 3'd2,
      ACT_SEARCH     = 3'd3,
      ACT_SORT       = 3'd4,
      ACT_FILTER     = 3'd5,
      ACT_READ_ALL   = 3'd6
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SORT,
      ST_SORT_DONE,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      ROW_HOLD,
      ROW_WRITE,
      ROW_PUSH_FRONT,
      ROW_ROTATE,
      ROW_SORT
   } row_op_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      row_op_type op;
      logic       parity;
      data_type   ins;
      data_type   key;
   } row_ctl_type;

   // per-cell status gathered from the row
   typedef struct packed {
      data_type head;
      mask_type eq_mask;
      mask_type gt_mask;
      mask_type valid_mask;
   } row_status_type;

endpackage

FILE: hdl/sss_req_if.sv
// input channel of the sequence store: action code and value
// depends on sss_pkg
interface sss_req_if;
   logic                          valid;
   logic                          ready;
   logic [sss_pkg::ACTION_W-1:0]  action;
   logic signed [sss_pkg::DATA_W-1:0] value;

   modport source (output valid, action, value, input ready);
   modport sink   (input valid, action, value, output ready);
endinterface

FILE: hdl/sss_rsp_if.sv
// result channel of the sequence store: emitted element and status fields
// depends on sss_pkg
interface sss_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [sss_pkg::DATA_W-1:0] data_out;
   logic                              data_valid;
   logic                              found;
   logic [sss_pkg::POS_W-1:0]         position;
   logic [sss_pkg::HELD_W-1:0]        held_count;
   logic                              overflow;
   logic                              last;

   modport source (output valid, data_out, data_valid, found, position, held_count,
                   overflow, last, input ready);
   modport sink   (input valid, data_out, data_valid, found, position, held_count,
                   overflow, last, output ready);
endinterface

FILE: hdl/sequence_store_sort_search.sv
// push, clear and search: the result beat is registered in the cycle after the request beat
// sort: CAPACITY odd-even transposition phases over the cell row, then one result beat
// filter and read all: CAPACITY row rotations, one result beat per emitted element
// a new request beat is taken only when idle and the result register can load
// synchronous active-high reset empties the store and sets the threshold to 4
module sequence_store_sort_search (
   input  logic                              clock,
   input  logic                              reset,
   sss_req_if.sink                           req,
   sss_rsp_if.source                         rsp,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [sss_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [sss_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [sss_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                              pready
);

   sss_pkg::state_type      state_ff, state_in;
   sss_pkg::cnt_type        count_ff, count_in;
   sss_pkg::idx_type        step_ff, step_in;
   sss_pkg::mask_type       mask_ff, mask_in;
   sss_pkg::data_type       thr_ff, thr_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   sss_pkg::data_type       rsp_data_ff, rsp_data_in;
   logic                    rsp_dv_ff, rsp_dv_in;
   logic                    rsp_found_ff, rsp_found_in;
   sss_pkg::pos_type        rsp_pos_ff, rsp_pos_in;
   sss_pkg::held_type       rsp_held_ff, rsp_held_in;
   logic                    rsp_ovf_ff, rsp_ovf_in;
   logic                    rsp_last_ff, rsp_last_in;

   sss_pkg::row_ctl_type    ctl;
   sss_pkg::row_status_type status;

   logic                    out_free;
   logic                    accept;
   logic                    out_load;
   logic                    csr_wr;
   sss_pkg::mask_type       hits;
   sss_pkg::mask_type       sel_mask;
   sss_pkg::idx_type        first_hit;

   sss_row u_row (
      .clock  (clock),
      .ctl    (ctl),
      .count  (count_ff),
      .status (status)
   );

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == sss_pkg::ST_IDLE) && out_free;
   assign accept    = req.valid && req.ready;

   // csr port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;
   assign thr_in = (csr_wr && (paddr[sss_pkg::CSR_ADDR_W-1:2] == sss_pkg::REG_FILTER_THRESHOLD))
                   ? sss_pkg::data_type'(pwdata) : thr_ff;
   assign prdata = (paddr[sss_pkg::CSR_ADDR_W-1:2] == sss_pkg::REG_FILTER_THRESHOLD)
                   ? sss_pkg::CSR_DATA_W'(thr_ff) : '0;

   // row command depends only on state, request and result handshake, never on row status
   always_comb begin
      ctl.op     = sss_pkg::ROW_HOLD;
      ctl.parity = step_ff[0];
      ctl.ins    = req.value;
      ctl.key    = thr_ff;
      case (state_ff)
         sss_pkg::ST_IDLE: begin
            if (req.action == sss_pkg::ACT_SEARCH) begin
               ctl.key = req.value;
            end
            if (accept && (count_ff != sss_pkg::cnt_type'(sss_pkg::CAPACITY))) begin
               if (req.action == sss_pkg::ACT_APPEND) begin
                  ctl.op = sss_pkg::ROW_WRITE;
               end else if (req.action == sss_pkg::ACT_PUSH_FRONT) begin
                  ctl.op = sss_pkg::ROW_PUSH_FRONT;
               end
            end
         end
         sss_pkg::ST_SORT: begin
            ctl.op = sss_pkg::ROW_SORT;
         end
         sss_pkg::ST_EMIT: begin
            if (!mask_ff[0] || out_free) begin
               ctl.op = sss_pkg::ROW_ROTATE;
            end
         end
         default: begin
            ctl.op = sss_pkg::ROW_HOLD;
         end
      endcase
   end

   // first matching cell from the front
   assign hits = status.eq_mask & status.valid_mask;
   always_comb begin
      first_hit = '0;
      for (int k = sss_pkg::CAPACITY - 1; k >= 0; k--) begin
         if (hits[k]) begin
            first_hit = sss_pkg::idx_type'(k);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      step_in      = step_ff;
      mask_in      = mask_ff;
      out_load     = 1'b0;
      rsp_data_in  = '0;
      rsp_dv_in    = 1'b0;
      rsp_found_in = 1'b0;
      rsp_pos_in   = '0;
      rsp_ovf_in   = 1'b0;
      rsp_last_in  = 1'b1;
      sel_mask     = status.valid_mask;
      case (state_ff)
         sss_pkg::ST_IDLE: begin
            if (accept) begin
               case (req.action)
                  sss_pkg::ACT_APPEND, sss_pkg::ACT_PUSH_FRONT: begin
                     out_load = 1'b1;
                     if (count_ff == sss_pkg::cnt_type'(sss_pkg::CAPACITY)) begin
                        rsp_ovf_in = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  sss_pkg::ACT_CLEAR: begin
                     out_load = 1'b1;
                     count_in = '0;
                  end
                  sss_pkg::ACT_SEARCH: begin
                     out_load = 1'b1;
                     if (hits != '0) begin
                        rsp_found_in = 1'b1;
                        rsp_pos_in   = sss_pkg::pos_type'(first_hit);
                     end
                  end
                  sss_pkg::ACT_SORT: begin
                     state_in = sss_pkg::ST_SORT;
                     step_in  = '0;
                  end
                  sss_pkg::ACT_FILTER, sss_pkg::ACT_READ_ALL: begin
                     if (req.action == sss_pkg::ACT_FILTER) begin
                        sel_mask = status.gt_mask & status.valid_mask;
                     end
                     if (sel_mask == '0) begin
                        out_load = 1'b1;
                     end else begin
                        mask_in  = sel_mask;
                        step_in  = '0;
                        state_in = sss_pkg::ST_EMIT;
                     end
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         sss_pkg::ST_SORT: begin
            step_in = step_ff + 1'b1;
            if (step_ff == sss_pkg::idx_type'(sss_pkg::CAPACITY - 1)) begin
               state_in = sss_pkg::ST_SORT_DONE;
            end
         end
         sss_pkg::ST_SORT_DONE: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = sss_pkg::ST_IDLE;
            end
         end
         sss_pkg::ST_EMIT: begin
            // full rotation restores the original order at the end
            if (!mask_ff[0] || out_free) begin
               mask_in = mask_ff >> 1;
               step_in = step_ff + 1'b1;
               if (mask_ff[0]) begin
                  out_load    = 1'b1;
                  rsp_data_in = status.head;
                  rsp_dv_in   = 1'b1;
                  rsp_last_in = ((mask_ff >> 1) == '0);
               end
               if (step_ff == sss_pkg::idx_type'(sss_pkg::CAPACITY - 1)) begin
                  state_in = sss_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sss_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_held_in  = sss_pkg::held_type'(count_in);
   assign rsp_valid_in = out_load ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sss_pkg::ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         mask_ff      <= '0;
         thr_ff       <= sss_pkg::THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         mask_ff      <= mask_in;
         thr_ff       <= thr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_dv_ff    <= rsp_dv_in;
         rsp_found_ff <= rsp_found_in;
         rsp_pos_ff   <= rsp_pos_in;
         rsp_held_ff  <= rsp_held_in;
         rsp_ovf_ff   <= rsp_ovf_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.data_out   = rsp_data_ff;
   assign rsp.data_valid = rsp_dv_ff;
   assign rsp.found      = rsp_found_ff;
   assign rsp.position   = rsp_pos_ff;
   assign rsp.held_count = rsp_held_ff;
   assign rsp.overflow   = rsp_ovf_ff;
   assign rsp.last       = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sss_pkg::cnt_type'(sss_pkg::CAPACITY))
      else $error("element count above capacity");

   a_emit_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sss_pkg::ST_IDLE && state_in == sss_pkg::ST_EMIT) |=> (mask_ff != '0))
      else $error("emit entered with nothing to send");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ovf_ff) |-> (count_ff == sss_pkg::cnt_type'(sss_pkg::CAPACITY)))
      else $error("overflow flagged while store not full");

   a_sort_done_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sss_pkg::ST_SORT_DONE) |->
         ($past(state_ff) == sss_pkg::ST_SORT || $past(state_ff) == sss_pkg::ST_SORT_DONE))
      else $error("sort finished without running its phases");

   a_emit_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sss_pkg::ST_EMIT || state_ff == sss_pkg::ST_SORT) |=> $stable(count_ff))
      else $error("element count changed during a multi-cycle action");

endmodule

FILE: hdl/sss_cell.sv
// one storage cell of the row: holds one element, trades with its neighbors
// depends on sss_pkg
module sss_cell (
   input  logic                 clock,
   input  sss_pkg::row_ctl_type ctl,
   input  sss_pkg::data_type    prev_data,
   input  sss_pkg::data_type    next_data,
   input  logic                 sel_write,
   input  logic                 as_lower,
   input  logic                 as_upper,
   output sss_pkg::data_type    data,
   output logic                 eq,
   output logic                 gt
);

   sss_pkg::data_type data_ff;
   sss_pkg::data_type data_in;

   always_comb begin
      data_in = data_ff;
      case (ctl.op)
         sss_pkg::ROW_WRITE: begin
            if (sel_write) begin
               data_in = ctl.ins;
            end
         end
         sss_pkg::ROW_PUSH_FRONT: begin
            data_in = prev_data;
         end
         sss_pkg::ROW_ROTATE: begin
            data_in = next_data;
         end
         sss_pkg::ROW_SORT: begin
            // lower member keeps the min, upper member keeps the max
            if (as_lower && (data_ff > next_data)) begin
               data_in = next_data;
            end else if (as_upper && (prev_data > data_ff)) begin
               data_in = prev_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
   assign eq   = (data_ff == ctl.key);
   assign gt   = (data_ff > ctl.key);

endmodule

FILE: hdl/sss_row.sv
// row of storage cells with neighbor wiring, write select and sort pairing
// depends on sss_pkg and sss_cell
module sss_row (
   input  logic                    clock,
   input  sss_pkg::row_ctl_type    ctl,
   input  sss_pkg::cnt_type        count,
   output sss_pkg::row_status_type status
);

   sss_pkg::data_type cell_data [sss_pkg::CAPACITY];
   sss_pkg::mask_type valid_mask;
   sss_pkg::mask_type lower;
   sss_pkg::mask_type upper;
   sss_pkg::mask_type eq_mask;
   sss_pkg::mask_type gt_mask;
   logic [sss_pkg::CAPACITY-2:0] pair_act;

   genvar i;
   generate
      for (i = 0; i < sss_pkg::CAPACITY; i++) begin : g_cell
         sss_pkg::data_type prev_d;
         sss_pkg::data_type next_d;
         logic              sel_w;

         assign valid_mask[i] = (sss_pkg::cnt_type'(i) < count);
         assign sel_w         = (sss_pkg::cnt_type'(i) == count);

         if (i == 0) begin : g_head
            assign prev_d   = ctl.ins;
            assign upper[i] = 1'b0;
         end else begin : g_body
            assign prev_d   = cell_data[i-1];
            assign upper[i] = pair_act[i-1];
         end

         // rotation wraps the head back to the tail
         if (i == sss_pkg::CAPACITY - 1) begin : g_tail
            assign next_d   = cell_data[0];
            assign lower[i] = 1'b0;
         end else begin : g_mid
            assign next_d      = cell_data[i+1];
            assign pair_act[i] = (1'(i % 2) == ctl.parity) && valid_mask[i+1];
            assign lower[i]    = pair_act[i];
         end

         sss_cell u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .prev_data (prev_d),
            .next_data (next_d),
            .sel_write (sel_w),
            .as_lower  (lower[i]),
            .as_upper  (upper[i]),
            .data      (cell_data[i]),
            .eq        (eq_mask[i]),
            .gt        (gt_mask[i])
         );
      end
   endgenerate

   assign status.head       = cell_data[0];
   assign status.eq_mask    = eq_mask;
   assign status.gt_mask    = gt_mask;
   assign status.valid_mask = valid_mask;

endmodule

FILE: tb/sv/testbench.sv
// self-checking bench for the sequence store: a directed table, then random action streams
// expected beats come from the table or an in-bench model; needs sss_pkg, sss_req_if, sss_rsp_if and the store design
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [sss_pkg::ACTION_W-1:0]   ACT_RESERVED    = 3'd7;
   localparam logic [sss_pkg::CSR_ADDR_W-1:0] THRESHOLD_ADDR  =
      {sss_pkg::REG_FILTER_THRESHOLD, 2'b00};
   localparam sss_pkg::data_type              MIN_ELEM        = 32'sh8000_0000;
   localparam sss_pkg::data_type              MAX_ELEM        = 32'sh7fff_ffff;
   localparam int                             STALL_LIMIT     = 4000;
   localparam int                             DRAIN_CYCLES    = 2 * sss_pkg::CAPACITY + 8;
   localparam int                             PHASES          = 6;
   localparam int                             ITEMS_PER_PHASE = 15;
   localparam int                             NUM_ROWS        = 19;

   typedef struct packed {
      sss_pkg::data_type data_out;
      logic              data_valid;
      logic              found;
      sss_pkg::pos_type  position;
      sss_pkg::held_type held_count;
      logic              overflow;
      logic              last;
   } store_reply_type;

   typedef struct packed {
      logic [sss_pkg::ACTION_W-1:0] act;
      sss_pkg::data_type            val;
      logic [4:0]                   reps;
      logic                         typed;
      store_reply_type              want;
   } plan_row_type;

   localparam store_reply_type NO_REPLY = '0;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [sss_pkg::CSR_ADDR_W-1:0] paddr;
   logic [sss_pkg::CSR_DATA_W-1:0] pwdata;
   logic [sss_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;

   sss_req_if req_ch ();
   sss_rsp_if rsp_ch ();

   sequence_store_sort_search u_top (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sss_pkg::data_type model_slots [sss_pkg::CAPACITY];
   int                model_fill;
   sss_pkg::data_type model_threshold;
   store_reply_type   awaited_replies [$];
   plan_row_type      plan [NUM_ROWS];
   int                fail_count         = 0;
   int                sender_gap_pct     = 19;
   int                receiver_stall_pct = 87;
   int                stall_cycles       = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   task automatic check_field(string what, logic signed [63:0] want, logic signed [63:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t mismatch %s: expected %0d, got %0d", $time, what, want, got);
      end
   endtask

   function automatic store_reply_type status_reply(int held, bit hit, int pos, bit refused);
      store_reply_type r;
      r            = '0;
      r.held_count = sss_pkg::held_type'(held);
      r.found      = hit;
      r.position   = sss_pkg::pos_type'(pos);
      r.overflow   = refused;
      r.last       = 1'b1;
      return r;
   endfunction

   function automatic void await_reply(store_reply_type r);
      awaited_replies = {awaited_replies, r};
   endfunction

   // updates the model store and, when record is set, queues the beats it should emit
   function automatic void predict_store_action(logic [sss_pkg::ACTION_W-1:0] act,
                                                sss_pkg::data_type val, bit record);
      store_reply_type   r;
      sss_pkg::data_type t;
      int                pending;
      bit                streamed;
      bit                picked;
      r        = '0;
      r.last   = 1'b1;
      streamed = 1'b0;
      case (act)
         sss_pkg::ACT_APPEND, sss_pkg::ACT_PUSH_FRONT: begin
            if (model_fill >= sss_pkg::CAPACITY) begin
               r.overflow = 1'b1;
            end else if (act == sss_pkg::ACT_APPEND) begin
               model_slots[model_fill] = val;
               model_fill++;
            end else begin
               for (int i = model_fill; i > 0; i--) model_slots[i] = model_slots[i-1];
               model_slots[0] = val;
               model_fill++;
            end
         end
         sss_pkg::ACT_CLEAR: model_fill = 0;
         sss_pkg::ACT_SEARCH: begin
            // scanning from the back leaves the first match in place
            for (int i = model_fill - 1; i >= 0; i--) begin
               if (model_slots[i] == val) begin
                  r.found    = 1'b1;
                  r.position = sss_pkg::pos_type'(i);
               end
            end
         end
         sss_pkg::ACT_SORT: begin
            for (int p = 0; p + 1 < model_fill; p++) begin
               for (int j = 0; j + 1 < model_fill; j++) begin
                  if (model_slots[j] > model_slots[j+1]) begin
                     t                = model_slots[j];
                     model_slots[j]   = model_slots[j+1];
                     model_slots[j+1] = t;
                  end
               end
            end
         end
         sss_pkg::ACT_FILTER, sss_pkg::ACT_READ_ALL: begin
            pending = 0;
            for (int i = 0; i < model_fill; i++) begin
               if (act == sss_pkg::ACT_READ_ALL || model_slots[i] > model_threshold) pending++;
            end
            streamed = (pending > 0);
            for (int i = 0; i < model_fill; i++) begin
               picked = (act == sss_pkg::ACT_READ_ALL || model_slots[i] > model_threshold);
               if (picked) begin
                  pending--;
                  r            = '0;
                  r.data_out   = model_slots[i];
                  r.data_valid = 1'b1;
                  r.held_count = sss_pkg::held_type'(model_fill);
                  r.last       = (pending == 0);
                  if (record) await_reply(r);
               end
            end
         end
         default: ;
      endcase
      if (!streamed) begin
         r.held_count = sss_pkg::held_type'(model_fill);
         if (record) await_reply(r);
      end
   endfunction

   function automatic sss_pkg::data_type draw_element();
      case ($urandom_range(3))
         0:       return sss_pkg::data_type'($urandom());
         1:       return $urandom_range(1) ? MAX_ELEM : MIN_ELEM;
         default: return sss_pkg::data_type'(int'($urandom_range(16)) - 8);
      endcase
   endfunction

   // valid stays up after a beat; only a gap or the drain lowers it
   task automatic send_beat(logic [sss_pkg::ACTION_W-1:0] act, sss_pkg::data_type val);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.action <= act;
      req_ch.value  <= val;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   // leaves psel up so a following transfer can start in the same cycle
   task automatic threshold_access(bit wr, sss_pkg::data_type wdata,
                                   output logic [sss_pkg::CSR_DATA_W-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= THRESHOLD_ADDR;
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
   endtask

   task automatic check_threshold_readback();
      logic [sss_pkg::CSR_DATA_W-1:0] got;
      threshold_access(1'b0, '0, got);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      check_field("filter_threshold", model_threshold, sss_pkg::data_type'(got));
   endtask

   task automatic set_threshold(sss_pkg::data_type thr);
      logic [sss_pkg::CSR_DATA_W-1:0] ignored;
      threshold_access(1'b1, thr, ignored);
      model_threshold = thr;
      check_threshold_readback();
   endtask

   task automatic random_burst(int count);
      logic [sss_pkg::ACTION_W-1:0] act;
      sss_pkg::data_type            val;
      int                           roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         // a full store is emptied again on a quarter of the draws so fills repeat
         if (model_fill == sss_pkg::CAPACITY && roll < 25) begin
            act = sss_pkg::ACT_CLEAR;
         end else begin
            roll = $urandom_range(99);
            if (roll < 32)      act = sss_pkg::ACT_APPEND;
            else if (roll < 55) act = sss_pkg::ACT_PUSH_FRONT;
            else if (roll < 67) act = sss_pkg::ACT_SEARCH;
            else if (roll < 75) act = sss_pkg::ACT_SORT;
            else if (roll < 85) act = sss_pkg::ACT_FILTER;
            else if (roll < 94) act = sss_pkg::ACT_READ_ALL;
            else if (roll < 97) act = ACT_RESERVED;
            else                act = sss_pkg::ACT_CLEAR;
         end
         if (act == sss_pkg::ACT_SEARCH && model_fill > 0 && $urandom_range(1))
            val = model_slots[$urandom_range(model_fill - 1)];
         else
            val = draw_element();
         send_beat(act, val);
         predict_store_action(act, val, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      store_reply_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_replies.size() == 0) begin
            fail_count++;
            $display("%0t unexpected result beat: expected none, got data_out %0d last %0d",
                     $time, rsp_ch.data_out, rsp_ch.last);
         end else begin
            want = awaited_replies.pop_front();
            check_field("data_out", want.data_out, rsp_ch.data_out);
            check_field("data_valid", want.data_valid, rsp_ch.data_valid);
            check_field("found", want.found, rsp_ch.found);
            check_field("position", want.position, rsp_ch.position);
            check_field("held_count", want.held_count, rsp_ch.held_count);
            check_field("overflow", want.overflow, rsp_ch.overflow);
            check_field("last", want.last, rsp_ch.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (psel && penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      sss_pkg::data_type val;
      sss_pkg::data_type thr;
      reset         = 1'b1;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      req_ch.valid  = 1'b0;
      req_ch.action = sss_pkg::ACT_APPEND;
      req_ch.value  = '0;
      model_fill      = 0;
      model_threshold = sss_pkg::THRESHOLD_RESET;
      foreach (model_slots[i]) model_slots[i] = '0;

      plan = '{
         '{sss_pkg::ACT_READ_ALL,   32'sd0,   5'd1,  1'b1, status_reply(0, 0, 0, 0)},
         '{sss_pkg::ACT_FILTER,     32'sd0,   5'd1,  1'b1, status_reply(0, 0, 0, 0)},
         '{sss_pkg::ACT_SEARCH,     32'sd0,   5'd1,  1'b1, status_reply(0, 0, 0, 0)},
         '{ACT_RESERVED,            -32'sd1,  5'd1,  1'b1, status_reply(0, 0, 0, 0)},
         '{sss_pkg::ACT_APPEND,     MAX_ELEM, 5'd1,  1'b1, status_reply(1, 0, 0, 0)},
         '{sss_pkg::ACT_PUSH_FRONT, MIN_ELEM, 5'd1,  1'b1, status_reply(2, 0, 0, 0)},
         '{sss_pkg::ACT_APPEND,     32'sd4,   5'd1,  1'b1, status_reply(3, 0, 0, 0)},
         '{sss_pkg::ACT_PUSH_FRONT, -32'sd1,  5'd1,  1'b1, status_reply(4, 0, 0, 0)},
         '{sss_pkg::ACT_SEARCH,     32'sd4,   5'd1,  1'b0, NO_REPLY},
         '{sss_pkg::ACT_FILTER,     32'sd0,   5'd1,  1'b0, NO_REPLY},
         '{sss_pkg::ACT_SORT,       32'sd0,   5'd1,  1'b0, NO_REPLY},
         '{sss_pkg::ACT_APPEND,     32'sd5,   5'd12, 1'b0, NO_REPLY},
         '{sss_pkg::ACT_PUSH_FRONT, 32'sd0,   5'd1,  1'b1, status_reply(16, 0, 0, 1)},
         '{sss_pkg::ACT_APPEND,     MAX_ELEM, 5'd1,  1'b1, status_reply(16, 0, 0, 1)},
         '{sss_pkg::ACT_SEARCH,     32'sd16,  5'd1,  1'b0, NO_REPLY},
         '{sss_pkg::ACT_READ_ALL,   32'sd0,   5'd1,  1'b0, NO_REPLY},
         '{sss_pkg::ACT_CLEAR,      32'sd0,   5'd1,  1'b1, status_reply(0, 0, 0, 0)},
         '{sss_pkg::ACT_APPEND,     32'sd7,   5'd1,  1'b1, status_reply(1, 0, 0, 0)},
         '{sss_pkg::ACT_SORT,       32'sd0,   5'd1,  1'b1, status_reply(1, 0, 0, 0)}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      check_threshold_readback();

      // rows with a typed reply only advance the model; the typed beat is what gets compared
      foreach (plan[row]) begin
         for (int k = 0; k < plan[row].reps; k++) begin
            val = plan[row].val + sss_pkg::data_type'(k);
            send_beat(plan[row].act, val);
            predict_store_action(plan[row].act, val, !plan[row].typed);
            if (plan[row].typed) await_reply(plan[row].want);
         end
      end
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       thr = MIN_ELEM;
            1:       thr = MAX_ELEM;
            2:       thr = 32'sd0;
            3:       thr = sss_pkg::data_type'($urandom());
            default: thr = sss_pkg::data_type'(int'($urandom_range(10)) - 5);
         endcase
         set_threshold(thr);
         if (ph < 2) begin
            sender_gap_pct     = 19;
            receiver_stall_pct = 87;
         end else if (ph < 4) begin
            sender_gap_pct     = 87;
            receiver_stall_pct = 19;
         end else begin
            sender_gap_pct     = 0;
            receiver_stall_pct = 0;
         end
         random_burst(ITEMS_PER_PHASE);
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
